// ----- rtl/tmwf_pkg.sv -----
package tmwf_pkg;

  // Sample and result width
  localparam int unsigned SAMPLE_W = 16;

  // Trimming applies from this many valid entries on
  localparam int unsigned TRIM_MIN_COUNT = 4;
  // Entries removed by trimming (one maximum, one minimum)
  localparam int unsigned TRIM_DROP = 2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_DIV,
    S_OUT
  } tmwf_state_e;

endpackage

// ----- rtl/tmwf_window_ram.sv -----
module tmwf_window_ram import tmwf_pkg::*; #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [SAMPLE_W-1:0] wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [SAMPLE_W-1:0] rdata_o
);

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  // Single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tmwf_div.sv -----
module tmwf_div import tmwf_pkg::*; #(
  parameter int unsigned NW = 20,  // dividend width
  parameter int unsigned DW = 4    // divisor width
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quot_q, quot_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   dvs_q;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     rem_shift;
  logic [DW:0]     rem_diff;
  logic            ge;

  // One restoring step: shift in next dividend bit, trial subtract
  assign rem_shift = {rem_q, quot_q[NW-1]};
  assign rem_diff  = rem_shift - {1'b0, dvs_q};
  assign ge        = (rem_shift >= {1'b0, dvs_q});

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CNTW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[NW-2:0], ge};
      rem_d  = ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

// ----- rtl/trimmed_mean_window_filter.sv -----
// Trimmed-mean moving window filter.
//
// Input channel (in_valid_i / in_ready_o / sample_i) takes one 16-bit sample
// per transaction; output channel (out_valid_o / out_ready_i / filtered_o)
// returns exactly one filtered value per input transaction, in order.
// Each sample is written into a circular window of WINDOW entries. With four
// or more valid entries the result is (sum - max - min) / (count - 2), else
// the truncating mean of the valid entries.
//
// The scan reads the window through the registered RAM read port, a setup
// state starts the bit-serial divider (one step per dividend bit, then a
// done strobe), and the quotient is then loaded into the output register.
// A new sample is taken only when the sequencer is idle, so the block does
// not take a new sample before it is through with the previous one.
// Reset clears the write pointer, fill count and all control state; the
// window contents are not cleared and are never read before being written.
// A stalled receiver holds the result in the output register; the block
// still accepts the next sample and parks its result until the slot frees.
module trimmed_mean_window_filter import tmwf_pkg::*; #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SAMPLE_W-1:0] filtered_o
);

  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned SW = SAMPLE_W + CW;

  tmwf_state_e state_q, state_d;

  logic [AW-1:0]       wpos_q;
  logic [CW-1:0]       fill_q;
  logic [CW-1:0]       k_q, k_d;
  logic                rd_vld_q, rd_vld_d;
  logic [SW-1:0]       sum_q;
  logic [SAMPLE_W-1:0] hi_q, lo_q;
  logic [SAMPLE_W-1:0] rdata;
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] filtered_q;
  logic                accept;
  logic                load_out;
  logic                div_start;
  logic                div_done;
  logic [SW-1:0]       div_num;
  logic [CW-1:0]       div_dvs;
  logic [SW-1:0]       div_quot;
  logic                trim;

  assign accept = in_valid_i && in_ready_o;

  // Window storage
  tmwf_window_ram #(
    .DEPTH (WINDOW),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wpos_q),
    .wdata_i (sample_i),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Shared bit-serial divider
  tmwf_div #(
    .NW (SW),
    .DW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Trim selection and divider operands
  assign trim    = (32'(fill_q) >= 32'(TRIM_MIN_COUNT));
  assign div_num = trim ? (sum_q - SW'(hi_q) - SW'(lo_q)) : sum_q;
  assign div_dvs = trim ? (fill_q - CW'(TRIM_DROP)) : fill_q;

  // Sequencer: next state and strobes
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    rd_vld_d    = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        k_d        = '0;
        if (in_valid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (k_q != fill_q) begin
          rd_vld_d = 1'b1;
          k_d      = k_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wpos_q      <= '0;
      fill_q      <= '0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        wpos_q <= (wpos_q == AW'(WINDOW - 1)) ? '0 : wpos_q + 1'b1;
        if (fill_q != CW'(WINDOW)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  // Scan accumulator: sum, max and min over returned reads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sum_q <= '0;
      hi_q  <= '0;
      lo_q  <= '1;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + SW'(rdata);
      if (rdata > hi_q) begin
        hi_q <= rdata;
      end
      if (rdata < lo_q) begin
        lo_q <= rdata;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      filtered_q <= div_quot[SAMPLE_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

  // Fill count never exceeds the window depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= WINDOW)
    else $error("fill count above window depth");

  // The scan index never runs past the fill count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (k_q <= fill_q))
    else $error("scan index beyond valid entries");

  // An accepted sample starts a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN))
    else $error("accepted sample did not start a scan");

  // Divider completion always moves to the output stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_done) |=> (state_q == S_OUT))
    else $error("divider result lost");

endmodule

// ----- tb/sv/tb_trimmed_mean_window_filter.sv -----
module tb_trimmed_mean_window_filter;
  import tmwf_pkg::*;

  localparam int unsigned WINDOW       = 8;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned DRAIN_CYCLES = 64;
  // Bound for roughly 1300 items with the longest sender and receiver gaps; keep a wide margin
  localparam int unsigned CYCLE_LIMIT  = 2_500_000;

  // Predicts the filter output per accepted sample and checks results in order
  class filtered_scoreboard #(int unsigned DEPTH = 8);
    logic [SAMPLE_W-1:0] history [DEPTH];
    int unsigned         wr_pos;
    int unsigned         fill_cnt;
    logic [SAMPLE_W-1:0] expected_q [$];
    int unsigned         errors;
    int unsigned         checked;
    int unsigned         accepted;
    int unsigned         trimmed;

    function new();
      wr_pos   = 0;
      fill_cnt = 0;
      errors   = 0;
      checked  = 0;
      accepted = 0;
      trimmed  = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    // Write the sample into the window and queue the expected filtered value
    function void note_sample(logic [SAMPLE_W-1:0] s);
      int unsigned sum;
      int unsigned hi;
      int unsigned lo;
      int unsigned res;
      history[wr_pos] = s;
      wr_pos = (wr_pos + 1) % DEPTH;
      if (fill_cnt < DEPTH) fill_cnt++;
      sum = 0;
      hi  = 0;
      lo  = (1 << SAMPLE_W) - 1;
      for (int unsigned k = 0; k < fill_cnt; k++) begin
        sum += history[k];
        if (history[k] > hi) hi = history[k];
        if (history[k] < lo) lo = history[k];
      end
      // Drop one max and one min once enough entries are valid
      if (fill_cnt >= TRIM_MIN_COUNT) begin
        res = (sum - hi - lo) / (fill_cnt - TRIM_DROP);
        trimmed++;
      end else begin
        res = sum / fill_cnt;
      end
      accepted++;
      expected_q.push_back(res[SAMPLE_W-1:0]);
    endfunction

    task check_filtered(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with no pending transaction", got));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (got !== want)
          report($sformatf("result #%0d filtered %h, predicted %h", checked, got, want));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [SAMPLE_W-1:0] sample_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [SAMPLE_W-1:0] filtered_o;

  filtered_scoreboard #(WINDOW) sb;
  bit                           no_idle;
  int unsigned                  cycles;

  trimmed_mean_window_filter #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .filtered_o (filtered_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 30);
    return $urandom_range(31, 150);
  endfunction

  function automatic int unsigned sender_gap();
    if (no_idle || $urandom_range(0, 99) < 55) return 0;
    return pick_gap();
  endfunction

  // Mix of uniform values, rails, small steps, repeats and small values
  function automatic logic [SAMPLE_W-1:0] gen_sample(logic [SAMPLE_W-1:0] prev);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return SAMPLE_W'($urandom_range(0, 65535));
    if (r < 60) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    if (r < 80) return prev + SAMPLE_W'($urandom_range(0, 64)) - SAMPLE_W'(32);
    if (r < 90) return prev;
    return SAMPLE_W'($urandom_range(0, 15));
  endfunction

  // Present one sample, hold until accepted, then idle for the given gap
  task automatic send_sample(logic [SAMPLE_W-1:0] s, int unsigned gap);
    in_valid_i = 1'b1;
    sample_i   = s;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      sample_i   = SAMPLE_W'($urandom_range(0, 65535));
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_results_drained();
    while (sb.pending() > 0) @(negedge clk_i);
  endtask

  // Monitor: both channels sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_sample(sample_i);
      if (out_valid_o && out_ready_i) sb.check_filtered(filtered_o);
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d results pending", cycles, sb.pending());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver back-pressure
  initial begin
    int unsigned stall;
    stall       = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        out_ready_i = 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 25) stall = pick_gap();
      end
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] directed [$];
    logic [SAMPLE_W-1:0] prev;
    sb         = new();
    no_idle    = 1'b0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    sample_i   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: plain mean while filling, rails, then repeated extremes
    directed = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000,
                 16'h7FFF, 16'hFFFE,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF,
                 16'h0000, 16'h0000, 16'h1234, 16'h0000, 16'hAAAA, 16'h5555};
    foreach (directed[i]) send_sample(directed[i], sender_gap());

    // Random part
    prev = directed[directed.size()-1];
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) begin
        // Sender holds off until the output side has caught up
        in_valid_i = 1'b0;
        wait_results_drained();
        @(negedge clk_i);
      end
      prev = gen_sample(prev);
      send_sample(prev, sender_gap());
    end
    in_valid_i = 1'b0;

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.pending() > 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.pending()));

    $display("Run covered %0d samples (%0d trimmed-mean, %0d plain-mean) with random stalls,",
             sb.accepted, sb.trimmed, sb.accepted - sb.trimmed);
    $display("%0d results compared, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
